// ===== sv/mde_pkg.sv =====
// Shared types, codes and Morse tables for the Morse duration encoder.
// No dependencies; every other file refers to this package by scoped names.
package mde_pkg;

   // Register indexes on the configuration port
   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_TIME     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_PAUSE = 2'd1;

   // Reset values of the configuration registers
   localparam logic [11:0] UNIT_TIME_RESET     = 12'd60;
   localparam logic [15:0] INITIAL_PAUSE_RESET = 16'd4000;

   // Gap that precedes the first symbol of a character
   localparam logic [1:0] GAP_NONE    = 2'd0;
   localparam logic [1:0] GAP_INITIAL = 2'd1;
   localparam logic [1:0] GAP_LETTER  = 2'd2;
   localparam logic [1:0] GAP_WORD    = 2'd3;

   // Pending gap state kept by the front end
   localparam logic [1:0] PEND_NONE   = 2'd0;
   localparam logic [1:0] PEND_LETTER = 2'd1;
   localparam logic [1:0] PEND_WORD   = 2'd2;

   // Morse pattern: symbol count, dash bits right-aligned with the first symbol at bit len-1
   typedef struct packed {
      logic [2:0] len;
      logic [4:0] pat;
   } code_type;

   // Work for the back end, one entry per character that yields output
   typedef struct packed {
      logic [1:0] gap;      // gap emitted before the symbols
      logic       has_sym;  // character has symbols
      logic [2:0] sym_len;  // number of symbols
      logic [4:0] sym_pat;  // dash bits, first symbol at bit 4
      logic       has_end;  // closing pause follows
      logic       end_on;   // closing pause is 7 units, else 0
   } job_type;

   function automatic code_type letter_code(input logic [4:0] idx);
      code_type c;
      begin
         case (idx)
            5'd0:    c = '{3'd2, 5'd1};
            5'd1:    c = '{3'd4, 5'd8};
            5'd2:    c = '{3'd4, 5'd10};
            5'd3:    c = '{3'd3, 5'd4};
            5'd4:    c = '{3'd1, 5'd0};
            5'd5:    c = '{3'd4, 5'd2};
            5'd6:    c = '{3'd3, 5'd6};
            5'd7:    c = '{3'd4, 5'd0};
            5'd8:    c = '{3'd2, 5'd0};
            5'd9:    c = '{3'd4, 5'd7};
            5'd10:   c = '{3'd3, 5'd5};
            5'd11:   c = '{3'd4, 5'd4};
            5'd12:   c = '{3'd2, 5'd3};
            5'd13:   c = '{3'd2, 5'd2};
            5'd14:   c = '{3'd3, 5'd7};
            5'd15:   c = '{3'd4, 5'd6};
            5'd16:   c = '{3'd4, 5'd13};
            5'd17:   c = '{3'd3, 5'd2};
            5'd18:   c = '{3'd3, 5'd0};
            5'd19:   c = '{3'd1, 5'd1};
            5'd20:   c = '{3'd3, 5'd1};
            5'd21:   c = '{3'd4, 5'd1};
            5'd22:   c = '{3'd3, 5'd3};
            5'd23:   c = '{3'd4, 5'd9};
            5'd24:   c = '{3'd4, 5'd11};
            5'd25:   c = '{3'd4, 5'd12};
            default: c = '{3'd1, 5'd0};
         endcase
         return c;
      end
   endfunction

   function automatic code_type digit_code(input logic [3:0] idx);
      code_type c;
      begin
         c.len = 3'd5;
         case (idx)
            4'd0:    c.pat = 5'd31;
            4'd1:    c.pat = 5'd15;
            4'd2:    c.pat = 5'd7;
            4'd3:    c.pat = 5'd3;
            4'd4:    c.pat = 5'd1;
            4'd5:    c.pat = 5'd0;
            4'd6:    c.pat = 5'd16;
            4'd7:    c.pat = 5'd24;
            4'd8:    c.pat = 5'd28;
            4'd9:    c.pat = 5'd30;
            default: c.pat = 5'd0;
         endcase
         return c;
      end
   endfunction

endpackage

// ===== sv/morse_duration_encoder_core.sv =====
// Morse duration encoder: text bytes in, on/off durations in ms out.
// Holds the configuration registers; instantiates mde_front, mde_queue, mde_back.
//
// Usage:
//   req_*  : one ASCII byte per item with an end-of-message flag. Accepted
//            when req_valid is high and req_stall low. The front end takes
//            one item per cycle while the job queue has room.
//   rsp_*  : one duration per item, accepted when rsp_valid is high and
//            rsp_stall low. rsp_last marks the closing pause of a message.
//   csr_*  : register writes (index 0 unit_time, 1 initial_pause), always
//            ready; write only while the block is idle.
// Path: an accepted byte is written to the job queue, then loaded into the
//   back-end job register, and its first duration goes to the output register.
// Throughput: one duration per cycle from the back-end sequencer while the
//   output is not stalled; a byte yields 0 to 11 durations (a digit after a
//   gap with the end flag yields 11). Bytes that yield nothing are not queued.
// Reset: clears message state, job queue and output register; configuration
//   returns to 60 ms unit and 4000 ms initial pause.
// Stall: a stalled result holds in the output register; the back end waits,
//   and the front end keeps accepting until the queue of QUEUE_DEPTH jobs fills.
module morse_duration_encoder_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_char_code,
   input  logic                            req_end_of_message,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [15:0]                     rsp_duration,
   output logic                            rsp_is_on,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mde_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0]                     csr_data
);

   logic [11:0] unit_time_ff;
   logic [15:0] initial_pause_ff;

   logic             push, queue_full, pop, head_valid;
   mde_pkg::job_type push_job, head_job;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_time_ff     <= mde_pkg::UNIT_TIME_RESET;
         initial_pause_ff <= mde_pkg::INITIAL_PAUSE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            mde_pkg::CSR_UNIT_TIME:     unit_time_ff     <= csr_data[11:0];
            mde_pkg::CSR_INITIAL_PAUSE: initial_pause_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   mde_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_code      (req_char_code),
      .req_end_of_message (req_end_of_message),
      .queue_full         (queue_full),
      .push               (push),
      .job                (push_job)
   );

   mde_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mde_back u_back (
      .clock         (clock),
      .reset         (reset),
      .unit_time     (unit_time_ff),
      .initial_pause (initial_pause_ff),
      .head_valid    (head_valid),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_duration  (rsp_duration),
      .rsp_is_on     (rsp_is_on),
      .rsp_last      (rsp_last)
   );

   // A closing pause is never a mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_is_on && rsp_last))
      else $error("closing pause flagged as mark");

   // The front end never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push |-> !queue_full)
      else $error("job pushed into full queue");

   // Nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

// ===== sv/mde_front.sv =====
// Front end of the Morse duration encoder: classifies each text byte,
// tracks message state and builds back-end jobs. Uses mde_pkg.
module mde_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_char_code,
   input  logic             req_end_of_message,
   input  logic             queue_full,
   output logic             push,
   output mde_pkg::job_type job
);

   logic       started_ff, started_in;
   logic [1:0] pending_ff, pending_in;

   logic [7:0]        folded;
   logic [7:0]        letter_off;
   logic [7:0]        digit_off;
   logic              is_letter, is_digit, is_space, is_sym, accept, end_on;
   mde_pkg::code_type code;

   // Fold case and classify the byte
   always_comb begin
      folded = req_char_code;
      if (req_char_code inside {[8'd97:8'd122]}) begin
         folded = req_char_code - 8'd32;
      end
      is_letter  = folded inside {[8'd65:8'd90]};
      is_digit   = req_char_code inside {[8'd48:8'd57]};
      is_space   = (req_char_code == 8'd32);
      is_sym     = is_letter || is_digit;
      letter_off = folded - 8'd65;
      digit_off  = req_char_code - 8'd48;
      if (is_letter) begin
         code = mde_pkg::letter_code(letter_off[4:0]);
      end else begin
         code = mde_pkg::digit_code(digit_off[3:0]);
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept && (is_sym || req_end_of_message);

   // Advance message state
   always_comb begin
      started_in = started_ff;
      pending_in = pending_ff;
      if (is_space && started_ff) begin
         pending_in = mde_pkg::PEND_WORD;
      end
      if (is_sym) begin
         started_in = 1'b1;
         pending_in = mde_pkg::PEND_LETTER;
      end
      end_on = started_in;
      if (req_end_of_message) begin
         started_in = 1'b0;
         pending_in = mde_pkg::PEND_NONE;
      end
   end

   // Build the job
   always_comb begin
      if (!started_ff) begin
         job.gap = mde_pkg::GAP_INITIAL;
      end else if (pending_ff == mde_pkg::PEND_LETTER) begin
         job.gap = mde_pkg::GAP_LETTER;
      end else if (pending_ff == mde_pkg::PEND_NONE) begin
         job.gap = mde_pkg::GAP_NONE;
      end else begin
         job.gap = mde_pkg::GAP_WORD;
      end
      if (!is_sym) begin
         job.gap = mde_pkg::GAP_NONE;
      end
      job.has_sym = is_sym;
      job.sym_len = code.len;
      job.sym_pat = code.pat << (3'd5 - code.len);
      job.has_end = req_end_of_message;
      job.end_on  = end_on;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         pending_ff <= mde_pkg::PEND_NONE;
      end else if (accept) begin
         started_ff <= started_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== sv/mde_queue.sv =====
// Short job queue between front and back end of the Morse encoder.
// Register-based circular buffer of mde_pkg::job_type entries.
module mde_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  mde_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output mde_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mde_pkg::job_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== sv/mde_back.sv =====
// Back end of the Morse encoder: plays out one job as a run of durations,
// one per cycle while the output is not stalled, into the output register. Uses mde_pkg.
module mde_back (
   input  logic             clock,
   input  logic             reset,
   input  logic [11:0]      unit_time,
   input  logic [15:0]      initial_pause,
   input  logic             head_valid,
   input  mde_pkg::job_type head_job,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [15:0]      rsp_duration,
   output logic             rsp_is_on,
   output logic             rsp_last
);

   localparam logic [1:0] PH_GAP   = 2'd0;
   localparam logic [1:0] PH_MARK  = 2'd1;
   localparam logic [1:0] PH_SPACE = 2'd2;
   localparam logic [1:0] PH_END   = 2'd3;

   logic             busy_ff, busy_in;
   logic [1:0]       phase_ff, phase_in;
   logic [2:0]       remain_ff, remain_in;
   logic [4:0]       pat_ff, pat_in;
   mde_pkg::job_type job_ff, job_in;

   logic             out_valid_ff, out_valid_in;
   logic [15:0]      out_dur_ff, out_dur_in;
   logic             out_on_ff, out_on_in;
   logic             out_last_ff, out_last_in;

   logic [15:0] u1, u3, u7;
   logic        out_free, emit, last_elem, load;

   // Unit multiples
   assign u1 = {4'd0, unit_time};
   assign u3 = (u1 << 1) + u1;
   assign u7 = (u1 << 3) - u1;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign emit     = busy_ff && out_free;

   // Select the current duration and whether it closes the job
   always_comb begin
      out_dur_in  = u1;
      out_on_in   = 1'b0;
      out_last_in = 1'b0;
      last_elem   = 1'b0;
      case (phase_ff)
         PH_GAP: begin
            case (job_ff.gap)
               mde_pkg::GAP_INITIAL: out_dur_in = initial_pause;
               mde_pkg::GAP_LETTER:  out_dur_in = u3;
               default:              out_dur_in = u7;
            endcase
            last_elem = !job_ff.has_sym && !job_ff.has_end;
         end
         PH_MARK: begin
            out_dur_in = pat_ff[4] ? u3 : u1;
            out_on_in  = 1'b1;
            last_elem  = (remain_ff == 3'd1) && !job_ff.has_end;
         end
         PH_SPACE: begin
            out_dur_in = u1;
         end
         PH_END: begin
            out_dur_in  = job_ff.end_on ? u7 : 16'd0;
            out_last_in = 1'b1;
            last_elem   = 1'b1;
         end
         default: begin
            out_dur_in = u1;
         end
      endcase
   end

   assign load = head_valid && (!busy_ff || (emit && last_elem));
   assign pop  = load;

   // Step the sequencer
   always_comb begin
      busy_in   = busy_ff;
      phase_in  = phase_ff;
      remain_in = remain_ff;
      pat_in    = pat_ff;
      job_in    = job_ff;
      if (load) begin
         busy_in   = 1'b1;
         job_in    = head_job;
         remain_in = head_job.sym_len;
         pat_in    = head_job.sym_pat;
         if (head_job.gap != mde_pkg::GAP_NONE) begin
            phase_in = PH_GAP;
         end else if (head_job.has_sym) begin
            phase_in = PH_MARK;
         end else begin
            phase_in = PH_END;
         end
      end else if (emit) begin
         if (last_elem) begin
            busy_in = 1'b0;
         end
         case (phase_ff)
            PH_GAP: phase_in = job_ff.has_sym ? PH_MARK : PH_END;
            PH_MARK: begin
               remain_in = remain_ff - 3'd1;
               pat_in    = pat_ff << 1;
               phase_in  = (remain_ff == 3'd1) ? PH_END : PH_SPACE;
            end
            PH_SPACE: phase_in = PH_MARK;
            default:  phase_in = PH_END;
         endcase
      end
   end

   assign out_valid_in = out_free ? busy_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         phase_ff     <= PH_GAP;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      remain_ff <= remain_in;
      pat_ff    <= pat_in;
      job_ff    <= job_in;
      if (emit) begin
         out_dur_ff  <= out_dur_in;
         out_on_ff   <= out_on_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_duration = out_dur_ff;
   assign rsp_is_on    = out_on_ff;
   assign rsp_last     = out_last_ff;

endmodule
